>>> rtl/core/lr_pkg.sv
// Shared constants for the line rasterizer.
package lr_pkg;

  // Guard bits of the signed error term beyond the coordinate width.
  localparam int unsigned LrErrGuardBits = 2;

  // Depth of the command queue between the setup stage and the walker.
  localparam int unsigned LrQueueDepth = 2;

endpackage

>>> rtl/core/line_rasterizer.sv
// Top level of the Bresenham line rasterizer.
//
// Input channel: in_valid_i / in_stall_o carries one segment per transaction
// as start and end pixel coordinates. Output channel: pixel_valid_o /
// pixel_stall_i carries one pixel per transaction, start pixel first, and
// last_pixel_o marks the end pixel. A segment gives max(|dx|, |dy|) + 1 pixels.
// A setup stage computes spans, directions and the initial error term and
// places the segment in a two-entry queue. The walker loads a segment from
// the queue and then emits one pixel per cycle while the receiver does not
// stall. With an empty queue, an accepted segment passes the setup register,
// the queue and the walker's segment registers before its first pixel is
// loaded into the output register. The setup stage and queue keep accepting
// segments while the walker is busy, up to three waiting segments.
// When the receiver stalls, the pixel register holds its value and the walk
// pauses; the input side stalls only when the queue and setup stage are full.
// Reset clears all valid flags and the queue; no pixel is pending afterward.
module line_rasterizer #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  pixel_valid_o,
  input  logic                  pixel_stall_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o
);
  import lr_pkg::*;

  localparam int unsigned CmdW = 6 * COORD_BITS + (COORD_BITS + LrErrGuardBits) + 2;

  logic            f_valid;
  logic            f_stall;
  logic [CmdW-1:0] f_cmd;
  logic            q_valid;
  logic            q_pop;
  logic [CmdW-1:0] q_cmd;
  logic            walk_busy;

  lr_front #(
    .COORD_BITS(COORD_BITS),
    .CMD_W     (CmdW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .cmd_valid_o(f_valid),
    .cmd_stall_i(f_stall),
    .cmd_o      (f_cmd)
  );

  lr_queue #(
    .DATA_W(CmdW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_stall_o(f_stall),
    .push_data_i (f_cmd),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_cmd)
  );

  lr_walker #(
    .COORD_BITS(COORD_BITS),
    .CMD_W     (CmdW)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_pop_o    (q_pop),
    .cmd_i        (q_cmd),
    .busy_o       (walk_busy),
    .pixel_valid_o(pixel_valid_o),
    .pixel_stall_i(pixel_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

  // A walk ends only by loading the end pixel into the output register.
  a_walk_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(walk_busy) |-> (pixel_valid_o && last_pixel_o))
    else $error("walker went idle without emitting the end pixel");

  // The walker never takes a new segment while one is in progress.
  a_no_pop_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_busy |-> !q_pop)
    else $error("segment popped while the walker was busy");

  // The input side stalls only when the setup stage holds a segment the queue cannot take.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (f_valid && f_stall && q_valid))
    else $error("input stalled without a full queue");

endmodule

>>> rtl/core/lr_front.sv
// Setup stage: accepts a segment and computes spans, directions and the initial error.
module lr_front #(
  parameter int unsigned COORD_BITS = 6,
  parameter int unsigned CMD_W      = 6 * COORD_BITS + (COORD_BITS + 2) + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_stall_i,
  output logic [CMD_W-1:0]      cmd_o
);
  import lr_pkg::*;

  localparam int unsigned ErrW = COORD_BITS + LrErrGuardBits;

  logic                   valid_q;
  logic                   accept;
  logic [COORD_BITS-1:0]  dx;
  logic [COORD_BITS-1:0]  dy;
  logic                   sx_neg;
  logic                   sy_neg;
  logic signed [ErrW-1:0] err_init;
  logic [CMD_W-1:0]       cmd_d;
  logic [CMD_W-1:0]       cmd_q;

  assign in_stall_o = valid_q && cmd_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    sx_neg = !(start_x_i < end_x_i);
    sy_neg = !(start_y_i < end_y_i);
    dx     = (end_x_i > start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
    dy     = (end_y_i > start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
    if (dx > dy) begin
      err_init = signed'(ErrW'({1'b0, dx[COORD_BITS-1:1]}));
    end else begin
      err_init = -signed'(ErrW'({1'b0, dy[COORD_BITS-1:1]}));
    end
    cmd_d = {start_x_i, start_y_i, end_x_i, end_y_i, dx, dy, sx_neg, sy_neg,
             ErrW'(err_init)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (!cmd_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> rtl/core/lr_queue.sv
// Small command queue between the setup stage and the pixel walker.
module lr_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_stall_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o
);
  import lr_pkg::*;

  localparam int unsigned PtrW = $clog2(LrQueueDepth);
  localparam int unsigned CntW = $clog2(LrQueueDepth + 1);

  logic [DATA_W-1:0] mem_q [LrQueueDepth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push;
  logic              pop;

  assign push_stall_o = (count_q == CntW'(LrQueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(LrQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(LrQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/lr_walker.sv
// Pixel walker: steps the Bresenham error walk and drives the output register.
module lr_walker #(
  parameter int unsigned COORD_BITS = 6,
  parameter int unsigned CMD_W      = 6 * COORD_BITS + (COORD_BITS + 2) + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_pop_o,
  input  logic [CMD_W-1:0]      cmd_i,
  output logic                  busy_o,
  output logic                  pixel_valid_o,
  input  logic                  pixel_stall_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o
);
  import lr_pkg::*;

  localparam int unsigned ErrW = COORD_BITS + LrErrGuardBits;

  logic                   busy_q;
  logic [COORD_BITS-1:0]  cur_x_q, cur_y_q, goal_x_q, goal_y_q, span_x_q, span_y_q;
  logic                   sx_neg_q, sy_neg_q;
  logic signed [ErrW-1:0] err_q;
  logic [COORD_BITS-1:0]  c_x, c_y, c_gx, c_gy, c_dx, c_dy;
  logic                   c_sx, c_sy;
  logic [ErrW-1:0]        c_err;
  logic                   out_valid_q;
  logic [COORD_BITS-1:0]  out_x_q, out_y_q;
  logic                   out_last_q;
  logic                   out_ready;
  logic                   emit;
  logic                   done;
  logic signed [ErrW-1:0] dx_s, dy_s, err_d;
  logic                   step_x, step_y;

  assign {c_x, c_y, c_gx, c_gy, c_dx, c_dy, c_sx, c_sy, c_err} = cmd_i;

  assign out_ready = !out_valid_q || !pixel_stall_i;
  assign cmd_pop_o = !busy_q && cmd_valid_i;
  assign emit      = busy_q && out_ready;
  assign done      = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);

  always_comb begin
    dx_s   = signed'(ErrW'(span_x_q));
    dy_s   = signed'(ErrW'(span_y_q));
    step_x = (err_q > -dx_s);
    step_y = (err_q < dy_s);
    err_d  = err_q;
    if (step_x) begin
      err_d = err_d - dy_s;
    end
    if (step_y) begin
      err_d = err_d + dx_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        busy_q <= 1'b1;
      end else if (emit && done) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!pixel_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_x_q  <= c_x;
      cur_y_q  <= c_y;
      goal_x_q <= c_gx;
      goal_y_q <= c_gy;
      span_x_q <= c_dx;
      span_y_q <= c_dy;
      sx_neg_q <= c_sx;
      sy_neg_q <= c_sy;
      err_q    <= signed'(c_err);
    end else if (emit && !done) begin
      err_q <= err_d;
      if (step_x) begin
        cur_x_q <= sx_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      end
      if (step_y) begin
        cur_y_q <= sy_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
    end
    if (emit) begin
      out_x_q    <= cur_x_q;
      out_y_q    <= cur_y_q;
      out_last_q <= done;
    end
  end

  assign busy_o        = busy_q;
  assign pixel_valid_o = out_valid_q;
  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign last_pixel_o  = out_last_q;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the line rasterizer with a queue-fed driver and a pixel monitor.
module tb;

  localparam int unsigned COORD_BITS     = 6;
  localparam int unsigned COORD_MAX      = (1 << COORD_BITS) - 1;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 80;

  typedef struct packed {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
  } segment_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [COORD_BITS-1:0] start_x_i = '0;
  logic [COORD_BITS-1:0] start_y_i = '0;
  logic [COORD_BITS-1:0] end_x_i = '0;
  logic [COORD_BITS-1:0] end_y_i = '0;
  logic                  pixel_valid_o;
  logic                  pixel_stall_i = 1'b0;
  logic [COORD_BITS-1:0] pixel_x_o;
  logic [COORD_BITS-1:0] pixel_y_o;
  logic                  last_pixel_o;

  segment_t    pending_segments[$];
  pixel_t      expected_pixels[$];
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        pressure_mode = 1'b0;
  logic        hold_done = 1'b0;
  logic        in_taken = 1'b0;

  line_rasterizer #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .pixel_valid_o(pixel_valid_o),
    .pixel_stall_i(pixel_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < 0) begin
      return '0;
    end else if (v > int'(COORD_MAX)) begin
      return COORD_MAX[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  // Bresenham walk over one segment, queueing every pixel it visits.
  task automatic walk_segment(input segment_t seg);
    int x, y, gx, gy, dx, dy, step_x, step_y, err, e, n;
    bit at_goal;
    pixel_t pix;
    x = seg.sx;
    y = seg.sy;
    gx = seg.ex;
    gy = seg.ey;
    dx = (gx > x) ? gx - x : x - gx;
    dy = (gy > y) ? gy - y : y - gy;
    step_x = (x < gx) ? 1 : -1;
    step_y = (y < gy) ? 1 : -1;
    err = (dx > dy) ? dx / 2 : -(dy / 2);
    n = 0;
    while (n < 64) begin
      at_goal = (x == gx) && (y == gy);
      pix.x = x[COORD_BITS-1:0];
      pix.y = y[COORD_BITS-1:0];
      pix.last = at_goal;
      expected_pixels.push_back(pix);
      n++;
      if (at_goal) break;
      e = err;
      if (e > -dx) begin
        err -= dy;
        x += step_x;
      end
      if (e < dy) begin
        err += dx;
        y += step_y;
      end
    end
  endtask

  task automatic add_segment(input int sx, input int sy, input int ex, input int ey);
    segment_t seg;
    seg.sx = sx[COORD_BITS-1:0];
    seg.sy = sy[COORD_BITS-1:0];
    seg.ex = ex[COORD_BITS-1:0];
    seg.ey = ey[COORD_BITS-1:0];
    pending_segments.push_back(seg);
    queued_count++;
  endtask

  task automatic wait_idle();
    while (accepted_count != queued_count || expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned send_pct, input int unsigned recv_pct,
                            input int count);
    int sx, sy, ex, ey, d;
    int unsigned kind;
    sender_idle_pct = send_pct;
    receiver_stall_pct = recv_pct;
    repeat (count) begin
      sx = $urandom_range(COORD_MAX);
      sy = $urandom_range(COORD_MAX);
      ex = $urandom_range(COORD_MAX);
      ey = $urandom_range(COORD_MAX);
      kind = $urandom_range(7);
      case (kind) inside
        [2:5]: begin
          ex = int'(clamp_coord(sx + int'($urandom_range(8)) - 4));
          ey = int'(clamp_coord(sy + int'($urandom_range(8)) - 4));
        end
        6: begin
          if ($urandom_range(1) == 0) ey = sy;
          else ex = sx;
        end
        7: begin
          d = $urandom_range(COORD_MAX);
          ex = int'(clamp_coord(($urandom_range(1) == 0) ? sx + d : sx - d));
          ey = int'(clamp_coord(($urandom_range(1) == 0) ? sy + d : sy - d));
        end
        default: ;
      endcase
      add_segment(sx, sy, ex, ey);
    end
    wait_idle();
  endtask

  // Segment driver: holds an offered transaction until it is taken.
  always @(negedge clk_i) begin
    if (in_valid_i && !in_taken) begin
      in_valid_i <= 1'b1;
    end else if (pending_segments.size() != 0 &&
                 $urandom_range(99) >= sender_idle_pct) begin
      segment_t seg;
      seg = pending_segments.pop_front();
      start_x_i <= seg.sx;
      start_y_i <= seg.sy;
      end_x_i <= seg.ex;
      end_y_i <= seg.ey;
      in_valid_i <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Pixel receiver stall, with one long hold-off in the pressure phase.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pixel_stall_i <= 1'b1;
    end else if (pressure_mode && !hold_done) begin
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
      pixel_stall_i <= 1'b1;
    end else begin
      pixel_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Monitor: predicts on accepted segments, checks accepted pixels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      logic seg_acc, pix_acc;
      pixel_t want;
      seg_acc = in_valid_i && !in_stall_o;
      pix_acc = pixel_valid_o && !pixel_stall_i;
      in_taken <= seg_acc;
      if (seg_acc) begin
        walk_segment({start_x_i, start_y_i, end_x_i, end_y_i});
        accepted_count++;
      end
      if (pix_acc) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                    pixel_x_o, pixel_y_o, last_pixel_o));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_x_o !== want.x)
            report_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x_o, want.x));
          if (pixel_y_o !== want.y)
            report_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y_o, want.y));
          if (last_pixel_o !== want.last)
            report_mismatch($sformatf("last_pixel %0b, want %0b at (%0d,%0d)",
                                      last_pixel_o, want.last, want.x, want.y));
        end
      end
      if (seg_acc || pix_acc) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("line_rasterizer verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    add_segment(0, 0, 0, 0);
    add_segment(63, 63, 63, 63);
    add_segment(0, 0, 63, 0);
    add_segment(63, 5, 0, 5);
    add_segment(7, 0, 7, 63);
    add_segment(9, 63, 9, 0);
    add_segment(0, 0, 63, 63);
    add_segment(63, 63, 0, 0);
    add_segment(0, 63, 63, 0);
    add_segment(63, 0, 0, 63);
    add_segment(10, 10, 20, 13);
    add_segment(10, 10, 21, 13);
    add_segment(30, 30, 20, 35);
    add_segment(30, 30, 33, 45);
    add_segment(30, 30, 27, 15);
    add_segment(40, 40, 35, 39);
    add_segment(5, 5, 6, 6);
    add_segment(5, 5, 6, 5);
    add_segment(5, 5, 9, 8);
    add_segment(5, 5, 8, 9);
    add_segment(63, 0, 62, 63);
    add_segment(0, 42, 63, 21);
    add_segment(21, 42, 42, 21);
    wait_idle();

    run_random(0, 0, 85);
    run_random(77, 0, 85);
    run_random(0, 77, 85);
    run_random(37, 37, 85);

    sender_idle_pct = 0;
    receiver_stall_pct = 20;
    pressure_mode = 1'b1;
    repeat (20) begin
      add_segment(0, $urandom_range(COORD_MAX), COORD_MAX, $urandom_range(COORD_MAX));
    end
    wait_idle();
    pressure_mode = 1'b0;
    receiver_stall_pct = 0;

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
    end
    if (mismatch_count == 0) begin
      $display("line_rasterizer verification clean");
    end else begin
      $display("line_rasterizer verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lr_pkg.sv
rtl/core/lr_front.sv
rtl/core/lr_queue.sv
rtl/core/lr_walker.sv
rtl/core/line_rasterizer.sv
sim/tb.sv
